### sv/rmie_pkg.sv
// Shared types and constants for the rendezvous message engine.
// No dependencies; used by the engine top level.
package rmie_pkg;

   localparam int PROC_COUNT_DEF  = 32;
   localparam int HANDLE_BITS_DEF = 32;

   // request kinds
   localparam logic [1:0] KIND_SEND = 2'd0;
   localparam logic [1:0] KIND_RECV = 2'd1;
   localparam logic [1:0] KIND_IRQ  = 2'd2;
   localparam logic [1:0] KIND_BAD  = 2'd3;

   // peer modes
   localparam logic [1:0] MODE_SPEC = 2'd0;
   localparam logic [1:0] MODE_ANY  = 2'd1;
   localparam logic [1:0] MODE_IRQ  = 2'd2;
   localparam logic [1:0] MODE_BAD  = 2'd3;

   // result status codes
   localparam logic [2:0] ST_DONE     = 3'd0;
   localparam logic [2:0] ST_BLOCKED  = 3'd1;
   localparam logic [2:0] ST_DEADLOCK = 3'd2;
   localparam logic [2:0] ST_INVALID  = 3'd3;
   localparam logic [2:0] ST_PENDING  = 3'd4;

   // result actions
   localparam logic [1:0] ACT_NONE = 2'd0;
   localparam logic [1:0] ACT_COPY = 2'd1;
   localparam logic [1:0] ACT_IRQ  = 2'd2;

   // wanted-source encodings (specific source is pid+1)
   localparam logic [6:0] WANT_NONE = 7'd0;
   localparam logic [6:0] WANT_ANY  = 7'd126;
   localparam logic [6:0] WANT_INT  = 7'd127;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DECODE,
      S_INT_CHK,
      S_CHAIN,
      S_CHAIN_CHK,
      S_SEND_CHK,
      S_BLOCK_SEND,
      S_APP_HEAD,
      S_APP_WALK,
      S_RCV_ANY,
      S_RCV_SPEC,
      S_RM_HEAD,
      S_RM_FIRST,
      S_RM_STEP,
      S_RM_CLR,
      S_HDL_RD,
      S_RCV_DONE
   } state_type;

endpackage

### sv/rmie_ram.sv
// Simple dual-port synchronous RAM: one write port, one registered read port.
// No dependencies.
module rmie_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

### sv/rendezvous_message_ipc_engine.sv
// Rendezvous message engine top level: process table, sender queues, control FSM.
// Depends on rmie_pkg and rmie_ram.
//
//  channel   | ports                          | handshake
//  ----------+--------------------------------+--------------------------------
//  request   | req_kind .. req_msg_handle     | transfer when start & !busy
//  response  | rsp_status .. rsp_woken_pid    | one-cycle strobe rsp_valid
//
// One request at a time; busy stays high until its response is issued.
// Invalid requests are answered from the decode state; the deadlock chain walk
// and each sender-queue walk step through the tables, whose reads are registered,
// and the sender-queue walks advance one entry per cycle.
// Synchronous reset clears flags, queue-head valid bits, rsp_valid and the FSM.
// The response is shown for one cycle; the receiver cannot stall it.
module rendezvous_message_ipc_engine #(
   parameter int PROC_COUNT  = rmie_pkg::PROC_COUNT_DEF,
   parameter int HANDLE_BITS = rmie_pkg::HANDLE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [4:0]  req_process_id,
   input  logic [4:0]  req_peer_pid,
   input  logic [1:0]  req_peer_mode,
   input  logic [31:0] req_msg_handle,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [1:0]  rsp_action,
   output logic [4:0]  rsp_copy_from_pid,
   output logic [31:0] rsp_copy_from_handle,
   output logic [4:0]  rsp_copy_to_pid,
   output logic [31:0] rsp_copy_to_handle,
   output logic        rsp_woken_valid,
   output logic [4:0]  rsp_woken_pid
);

   localparam int IW = $clog2(PROC_COUNT);
   localparam int PW = $clog2(PROC_COUNT + 1);
   localparam int HW = HANDLE_BITS;
   localparam logic [PW-1:0] NIL = PW'(PROC_COUNT);

   // control state
   rmie_pkg::state_type state_ff, state_in;
   logic [PROC_COUNT-1:0] snd_ff, snd_in, rcv_ff, rcv_in, irq_ff, irq_in;
   logic [PROC_COUNT-1:0] hv_ff, hv_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // request and walk registers
   logic [1:0]    kind_ff, kind_in, mode_ff, mode_in;
   logic [4:0]    me5_ff, me5_in, peer5_ff, peer5_in;
   logic [HW-1:0] h_ff, h_in;
   logic [PW-1:0] ptr_ff, ptr_in, prev_ff, prev_in, cnt_ff, cnt_in;
   logic [IW-1:0] from_ff, from_in;

   // response registers
   logic [2:0]  status_ff, status_in;
   logic [1:0]  action_ff, action_in;
   logic [4:0]  fpid_ff, fpid_in, tpid_ff, tpid_in, wpid_ff, wpid_in;
   logic [31:0] fh_ff, fh_in, th_ff, th_in;
   logic        wv_ff, wv_in;

   // memory ports
   logic          tgt_we, want_we, hdl_we, head_we, next_we;
   logic [IW-1:0] tgt_wa, want_wa, hdl_wa, head_wa, next_wa;
   logic [IW-1:0] tgt_ra, want_ra, hdl_ra, head_ra, next_ra;
   logic [IW-1:0] tgt_wd, tgt_q;
   logic [6:0]    want_wd, want_q;
   logic [HW-1:0] hdl_wd, hdl_q;
   logic [PW-1:0] head_wd, head_raw, next_wd, next_q;
   logic          head_vld_ff;
   logic [PW-1:0] head_q;

   rmie_ram #(.WIDTH(IW), .DEPTH(PROC_COUNT)) u_tgt (
      .clock(clock), .we(tgt_we), .waddr(tgt_wa), .wdata(tgt_wd),
      .raddr(tgt_ra), .rdata(tgt_q));
   rmie_ram #(.WIDTH(7), .DEPTH(PROC_COUNT)) u_want (
      .clock(clock), .we(want_we), .waddr(want_wa), .wdata(want_wd),
      .raddr(want_ra), .rdata(want_q));
   rmie_ram #(.WIDTH(HW), .DEPTH(PROC_COUNT)) u_hdl (
      .clock(clock), .we(hdl_we), .waddr(hdl_wa), .wdata(hdl_wd),
      .raddr(hdl_ra), .rdata(hdl_q));
   rmie_ram #(.WIDTH(PW), .DEPTH(PROC_COUNT)) u_head (
      .clock(clock), .we(head_we), .waddr(head_wa), .wdata(head_wd),
      .raddr(head_ra), .rdata(head_raw));
   rmie_ram #(.WIDTH(PW), .DEPTH(PROC_COUNT)) u_next (
      .clock(clock), .we(next_we), .waddr(next_wa), .wdata(next_wd),
      .raddr(next_ra), .rdata(next_q));

   // an empty queue head reads as NIL until first written
   always_ff @(posedge clock) begin
      head_vld_ff <= hv_ff[head_ra];
   end
   assign head_q = head_vld_ff ? head_raw : NIL;

   // decoded request fields
   logic [IW-1:0] me, peer;
   logic          me_bad, peer_bad;
   assign me       = IW'(me5_ff);
   assign peer     = IW'(peer5_ff);
   assign me_bad   = 32'(me5_ff) >= PROC_COUNT;
   assign peer_bad = (32'(peer5_ff) >= PROC_COUNT) || (peer5_ff == me5_ff);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rmie_pkg::S_IDLE;
         snd_ff       <= '0;
         rcv_ff       <= '0;
         irq_ff       <= '0;
         hv_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         snd_ff       <= snd_in;
         rcv_ff       <= rcv_in;
         irq_ff       <= irq_in;
         hv_ff        <= hv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      mode_ff   <= mode_in;
      me5_ff    <= me5_in;
      peer5_ff  <= peer5_in;
      h_ff      <= h_in;
      ptr_ff    <= ptr_in;
      prev_ff   <= prev_in;
      cnt_ff    <= cnt_in;
      from_ff   <= from_in;
      status_ff <= status_in;
      action_ff <= action_in;
      fpid_ff   <= fpid_in;
      fh_ff     <= fh_in;
      tpid_ff   <= tpid_in;
      th_ff     <= th_in;
      wv_ff     <= wv_in;
      wpid_ff   <= wpid_in;
   end

   // next state, table updates and response
   always_comb begin
      logic done;
      logic [PW-1:0] nx;
      done = 1'b0;
      nx   = next_q;

      state_in = state_ff;
      snd_in = snd_ff;
      rcv_in = rcv_ff;
      irq_in = irq_ff;
      hv_in  = hv_ff;
      kind_in = kind_ff;
      mode_in = mode_ff;
      me5_in = me5_ff;
      peer5_in = peer5_ff;
      h_in = h_ff;
      ptr_in = ptr_ff;
      prev_in = prev_ff;
      cnt_in = cnt_ff;
      from_in = from_ff;

      status_in = rmie_pkg::ST_INVALID;
      action_in = rmie_pkg::ACT_NONE;
      fpid_in = '0;
      fh_in = '0;
      tpid_in = '0;
      th_in = '0;
      wv_in = 1'b0;
      wpid_in = '0;

      tgt_we = 1'b0;  tgt_wa = me;  tgt_wd = peer;  tgt_ra = '0;
      want_we = 1'b0; want_wa = me; want_wd = rmie_pkg::WANT_NONE; want_ra = '0;
      hdl_we = 1'b0;  hdl_wa = me;  hdl_wd = h_ff;  hdl_ra = '0;
      head_we = 1'b0; head_wa = me; head_wd = NIL;  head_ra = '0;
      next_we = 1'b0; next_wa = me; next_wd = NIL;  next_ra = '0;

      unique case (state_ff)
         rmie_pkg::S_IDLE: begin
            if (start) begin
               kind_in  = req_kind;
               mode_in  = req_peer_mode;
               me5_in   = req_process_id;
               peer5_in = req_peer_pid;
               h_in     = HW'(req_msg_handle);
               state_in = rmie_pkg::S_DECODE;
            end
         end

         rmie_pkg::S_DECODE: begin
            if (kind_ff == rmie_pkg::KIND_BAD || me_bad) begin
               done = 1'b1;
            end else if (kind_ff == rmie_pkg::KIND_IRQ) begin
               if (rcv_ff[me]) begin
                  want_ra  = me;
                  hdl_ra   = me;
                  state_in = rmie_pkg::S_INT_CHK;
               end else begin
                  irq_in[me] = 1'b1;
                  status_in  = rmie_pkg::ST_PENDING;
                  done       = 1'b1;
               end
            end else if (snd_ff[me] || rcv_ff[me]) begin
               done = 1'b1;
            end else if (kind_ff == rmie_pkg::KIND_SEND) begin
               if (mode_ff != rmie_pkg::MODE_SPEC || peer_bad) begin
                  done = 1'b1;
               end else begin
                  ptr_in   = PW'(peer);
                  cnt_in   = '0;
                  state_in = rmie_pkg::S_CHAIN;
               end
            end else begin
               if (mode_ff == rmie_pkg::MODE_BAD ||
                   (mode_ff == rmie_pkg::MODE_SPEC && peer_bad)) begin
                  done = 1'b1;
               end else if (irq_ff[me] && mode_ff != rmie_pkg::MODE_SPEC) begin
                  irq_in[me] = 1'b0;
                  status_in  = rmie_pkg::ST_DONE;
                  action_in  = rmie_pkg::ACT_IRQ;
                  tpid_in    = me5_ff;
                  th_in      = 32'(h_ff);
                  done       = 1'b1;
               end else if (mode_ff == rmie_pkg::MODE_ANY) begin
                  head_ra  = me;
                  state_in = rmie_pkg::S_RCV_ANY;
               end else if (mode_ff == rmie_pkg::MODE_SPEC && snd_ff[peer]) begin
                  tgt_ra   = peer;
                  state_in = rmie_pkg::S_RCV_SPEC;
               end else begin
                  // receiver blocks
                  rcv_in[me] = 1'b1;
                  hdl_we     = 1'b1;
                  want_we    = 1'b1;
                  want_wd    = (mode_ff == rmie_pkg::MODE_ANY) ? rmie_pkg::WANT_ANY :
                               (mode_ff == rmie_pkg::MODE_IRQ) ? rmie_pkg::WANT_INT :
                               7'(peer5_ff) + 7'd1;
                  status_in  = rmie_pkg::ST_BLOCKED;
                  done       = 1'b1;
               end
            end
         end

         rmie_pkg::S_INT_CHK: begin
            if (want_q == rmie_pkg::WANT_INT || want_q == rmie_pkg::WANT_ANY) begin
               rcv_in[me] = 1'b0;
               irq_in[me] = 1'b0;
               want_we    = 1'b1;
               status_in  = rmie_pkg::ST_DONE;
               action_in  = rmie_pkg::ACT_IRQ;
               tpid_in    = me5_ff;
               th_in      = 32'(hdl_q);
               wv_in      = 1'b1;
               wpid_in    = me5_ff;
            end else begin
               irq_in[me] = 1'b1;
               status_in  = rmie_pkg::ST_PENDING;
            end
            done = 1'b1;
         end

         // deadlock walk along the send targets
         rmie_pkg::S_CHAIN: begin
            if (snd_ff[ptr_ff[IW-1:0]]) begin
               tgt_ra   = ptr_ff[IW-1:0];
               state_in = rmie_pkg::S_CHAIN_CHK;
            end else if (rcv_ff[peer]) begin
               want_ra  = peer;
               hdl_ra   = peer;
               state_in = rmie_pkg::S_SEND_CHK;
            end else begin
               state_in = rmie_pkg::S_BLOCK_SEND;
            end
         end

         rmie_pkg::S_CHAIN_CHK: begin
            if (tgt_q == me || cnt_ff == PW'(PROC_COUNT)) begin
               status_in = rmie_pkg::ST_DEADLOCK;
               done      = 1'b1;
            end else begin
               ptr_in   = PW'(tgt_q);
               cnt_in   = cnt_ff + PW'(1);
               state_in = rmie_pkg::S_CHAIN;
            end
         end

         rmie_pkg::S_SEND_CHK: begin
            if (want_q == 7'(me5_ff) + 7'd1 || want_q == rmie_pkg::WANT_ANY) begin
               rcv_in[peer] = 1'b0;
               want_we      = 1'b1;
               want_wa      = peer;
               status_in    = rmie_pkg::ST_DONE;
               action_in    = rmie_pkg::ACT_COPY;
               fpid_in      = me5_ff;
               fh_in        = 32'(h_ff);
               tpid_in      = peer5_ff;
               th_in        = 32'(hdl_q);
               wv_in        = 1'b1;
               wpid_in      = peer5_ff;
               done         = 1'b1;
            end else begin
               state_in = rmie_pkg::S_BLOCK_SEND;
            end
         end

         // sender blocks and joins the destination queue
         rmie_pkg::S_BLOCK_SEND: begin
            snd_in[me] = 1'b1;
            tgt_we     = 1'b1;
            hdl_we     = 1'b1;
            next_we    = 1'b1;
            head_ra    = peer;
            state_in   = rmie_pkg::S_APP_HEAD;
         end

         rmie_pkg::S_APP_HEAD: begin
            if (head_q >= NIL) begin
               head_we     = 1'b1;
               head_wa     = peer;
               head_wd     = PW'(me);
               hv_in[peer] = 1'b1;
               status_in   = rmie_pkg::ST_BLOCKED;
               done        = 1'b1;
            end else begin
               ptr_in   = head_q;
               cnt_in   = '0;
               next_ra  = head_q[IW-1:0];
               state_in = rmie_pkg::S_APP_WALK;
            end
         end

         rmie_pkg::S_APP_WALK: begin
            if (nx < NIL && cnt_ff < PW'(PROC_COUNT)) begin
               ptr_in  = nx;
               cnt_in  = cnt_ff + PW'(1);
               next_ra = nx[IW-1:0];
            end else begin
               next_we   = 1'b1;
               next_wa   = ptr_ff[IW-1:0];
               next_wd   = PW'(me);
               status_in = rmie_pkg::ST_BLOCKED;
               done      = 1'b1;
            end
         end

         rmie_pkg::S_RCV_ANY: begin
            if (head_q < NIL) begin
               from_in  = head_q[IW-1:0];
               state_in = rmie_pkg::S_RM_HEAD;
            end else begin
               rcv_in[me] = 1'b1;
               hdl_we     = 1'b1;
               want_we    = 1'b1;
               want_wd    = rmie_pkg::WANT_ANY;
               status_in  = rmie_pkg::ST_BLOCKED;
               done       = 1'b1;
            end
         end

         rmie_pkg::S_RCV_SPEC: begin
            if (tgt_q == me) begin
               from_in  = peer;
               state_in = rmie_pkg::S_RM_HEAD;
            end else begin
               rcv_in[me] = 1'b1;
               hdl_we     = 1'b1;
               want_we    = 1'b1;
               want_wd    = 7'(peer5_ff) + 7'd1;
               status_in  = rmie_pkg::ST_BLOCKED;
               done       = 1'b1;
            end
         end

         // unlink the sender from the caller's queue
         rmie_pkg::S_RM_HEAD: begin
            head_ra  = me;
            state_in = rmie_pkg::S_RM_FIRST;
         end

         rmie_pkg::S_RM_FIRST: begin
            ptr_in  = head_q;
            prev_in = NIL;
            cnt_in  = '0;
            if (head_q >= NIL) begin
               state_in = rmie_pkg::S_HDL_RD;
            end else begin
               next_ra  = head_q[IW-1:0];
               state_in = rmie_pkg::S_RM_STEP;
            end
         end

         rmie_pkg::S_RM_STEP: begin
            if (ptr_ff[IW-1:0] == from_ff) begin
               if (prev_ff >= NIL) begin
                  head_we   = 1'b1;
                  head_wa   = me;
                  head_wd   = nx;
                  hv_in[me] = 1'b1;
               end else begin
                  next_we = 1'b1;
                  next_wa = prev_ff[IW-1:0];
                  next_wd = nx;
               end
               state_in = rmie_pkg::S_RM_CLR;
            end else begin
               prev_in = ptr_ff;
               ptr_in  = nx;
               cnt_in  = cnt_ff + PW'(1);
               if (nx >= NIL || cnt_ff + PW'(1) >= PW'(PROC_COUNT)) begin
                  state_in = rmie_pkg::S_HDL_RD;
               end else begin
                  next_ra = nx[IW-1:0];
               end
            end
         end

         rmie_pkg::S_RM_CLR: begin
            next_we  = 1'b1;
            next_wa  = ptr_ff[IW-1:0];
            state_in = rmie_pkg::S_HDL_RD;
         end

         rmie_pkg::S_HDL_RD: begin
            hdl_ra   = from_ff;
            state_in = rmie_pkg::S_RCV_DONE;
         end

         rmie_pkg::S_RCV_DONE: begin
            snd_in[from_ff] = 1'b0;
            status_in = rmie_pkg::ST_DONE;
            action_in = rmie_pkg::ACT_COPY;
            fpid_in   = 5'(from_ff);
            fh_in     = 32'(hdl_q);
            tpid_in   = me5_ff;
            th_in     = 32'(h_ff);
            wv_in     = 1'b1;
            wpid_in   = 5'(from_ff);
            done      = 1'b1;
         end

         default: begin
            state_in = rmie_pkg::S_IDLE;
         end
      endcase

      rsp_valid_in = done;
      if (done) begin
         state_in = rmie_pkg::S_IDLE;
      end
   end

   assign busy                 = (state_ff != rmie_pkg::S_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = status_ff;
   assign rsp_action           = action_ff;
   assign rsp_copy_from_pid    = fpid_ff;
   assign rsp_copy_from_handle = fh_ff;
   assign rsp_copy_to_pid      = tpid_ff;
   assign rsp_copy_to_handle   = th_ff;
   assign rsp_woken_valid      = wv_ff;
   assign rsp_woken_pid        = wpid_ff;

endmodule
